// ===== hw/rtl/fsrq_pkg.sv =====
// Package for the FCFS/SJF request queue: queue depth, field widths, codes and
// the transaction and cell command structs. No dependencies.
package fsrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int SIZE_BITS   = 40;
   localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_SJF  = 1'b1;

   localparam logic [1:0] ST_ENQUEUED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_SERVED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic                 kind;
      logic [TAG_BITS-1:0]  request_tag;
      logic [SIZE_BITS-1:0] job_size;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [TAG_BITS-1:0]  served_tag;
      logic [SIZE_BITS-1:0] served_size;
      logic [OCC_BITS-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [SIZE_BITS-1:0] size;
   } entry_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      remove;
      logic      sjf;
      entry_type new_entry;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/fsrq_cell.sv =====
// One queue slot: holds an entry and shifts it towards the tail on insert
// or towards the head on remove. Depends on fsrq_pkg.
module fsrq_cell (
   input  logic                 clock,
   input  fsrq_pkg::cell_cmd_type cmd,
   input  logic                 occupied,
   input  logic                 at_tail,
   input  logic                 found_in,
   input  fsrq_pkg::entry_type  left_entry,
   input  fsrq_pkg::entry_type  right_entry,
   output fsrq_pkg::entry_type  entry,
   output logic                 found_out
);

   fsrq_pkg::entry_type entry_ff;
   fsrq_pkg::entry_type entry_in;
   logic                hit;

   // First slot that is either the tail or, under SJF, holds a size not below the new one
   assign hit = at_tail ||
                (cmd.sjf && occupied && (cmd.new_entry.size <= entry_ff.size));
   assign found_out = found_in || hit;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (found_in) begin
            entry_in = left_entry;
         end else if (hit) begin
            entry_in = cmd.new_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/fsrq_chain.sv =====
// Row of fsrq_cell slots, head at slot 0, with the insert-position ripple
// between neighbours. Depends on fsrq_pkg and fsrq_cell.
module fsrq_chain #(
   parameter int DEPTH    = 16,
   parameter int CNT_BITS = 5
) (
   input  logic                   clock,
   input  fsrq_pkg::cell_cmd_type cmd,
   input  logic [CNT_BITS-1:0]    count,
   output fsrq_pkg::entry_type    head
);

   fsrq_pkg::entry_type entries [DEPTH];
   logic [DEPTH:0]      found;

   assign found[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      fsrq_pkg::entry_type left_entry;
      fsrq_pkg::entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = cmd.new_entry;
      end else begin : g_mid_l
         assign left_entry = entries[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_mid_r
         assign right_entry = entries[i+1];
      end

      fsrq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CNT_BITS'(i) < count),
         .at_tail     (CNT_BITS'(i) == count),
         .found_in    (found[i]),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .found_out   (found[i+1])
      );
   end

   assign head = entries[0];

endmodule

// ===== hw/rtl/fcfs_sjf_request_queue_unit.sv =====
// Top level of the FCFS/SJF request queue: handshakes, policy register,
// fill count and result register. Depends on fsrq_pkg and fsrq_chain.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | fsrq_pkg::req_type
//   rsp     | out       | rsp_valid/stall  | fsrq_pkg::rsp_type
//   csr     | in        | csr_valid/ready  | policy bit
//
// One transaction per cycle while req is not stalled; its result is registered
// in the cycle after acceptance. All slots compare the new size in parallel and
// the insert position ripples through the cells combinationally.
// Reset empties the queue and selects FCFS. req is stalled only while a
// result is held under rsp_stall; csr writes are always taken.
module fcfs_sjf_request_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fsrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fsrq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int CNT_BITS = fsrq_pkg::OCC_BITS;

   logic                   policy_ff, policy_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fsrq_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                   accept;
   logic                   full, empty;
   fsrq_pkg::cell_cmd_type cmd;
   fsrq_pkg::entry_type    head;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign full  = (count_ff == CNT_BITS'(fsrq_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   assign cmd.insert = accept && (req_data.kind == fsrq_pkg::KIND_ENQUEUE) && !full;
   assign cmd.remove = accept && (req_data.kind == fsrq_pkg::KIND_DEQUEUE) && !empty;
   assign cmd.sjf    = (policy_ff == fsrq_pkg::POLICY_SJF);
   assign cmd.new_entry.tag  = req_data.request_tag;
   assign cmd.new_entry.size = req_data.job_size;

   fsrq_chain #(
      .DEPTH    (fsrq_pkg::QUEUE_DEPTH),
      .CNT_BITS (CNT_BITS)
   ) u_chain (
      .clock (clock),
      .cmd   (cmd),
      .count (count_ff),
      .head  (head)
   );

   always_comb begin
      policy_in = policy_ff;
      if (csr_valid && csr_ready) begin
         policy_in = csr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.served_tag  = '0;
         rsp_data_in.served_size = '0;
         rsp_data_in.occupancy   = fsrq_pkg::OCC_BITS'(count_in);
         unique case (req_data.kind)
            fsrq_pkg::KIND_ENQUEUE: begin
               rsp_data_in.status = full ? fsrq_pkg::ST_DROPPED : fsrq_pkg::ST_ENQUEUED;
            end
            fsrq_pkg::KIND_DEQUEUE: begin
               if (empty) begin
                  rsp_data_in.status = fsrq_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in.status      = fsrq_pkg::ST_SERVED;
                  rsp_data_in.served_tag  = head.tag;
                  rsp_data_in.served_size = head.size;
               end
            end
            default: begin
               rsp_data_in.status = fsrq_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= fsrq_pkg::POLICY_FCFS;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
